@@ src/msq_pkg.sv @@
// ----------------------------------------------------------------------------
// msq_pkg: shared types and helpers for the marching-squares cell block
// Corner value width, edge-group codes and the case-to-group lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  // corner level-set values are always Q16.16 in 32 bits
  localparam int unsigned PhiWidth = 32;

  // which pair of cell edges a case crosses
  typedef enum logic [2:0] {
    GRP_NONE   = 3'd0,
    GRP_SADDLE = 3'd1,
    GRP_TR     = 3'd2,
    GRP_BR     = 3'd3,
    GRP_TB     = 3'd4,
    GRP_LB     = 3'd5,
    GRP_LR     = 3'd6,
    GRP_TL     = 3'd7
  } msq_group_e;

  // case index (ul,ll,lr,ur) to edge group; complementary cases share a group
  function automatic msq_group_e msq_group(input logic [3:0] idx);
    msq_group_e g;
    case (idx)
      4'd1, 4'd14: g = GRP_TR;
      4'd2, 4'd13: g = GRP_BR;
      4'd3, 4'd12: g = GRP_TB;
      4'd4, 4'd11: g = GRP_LB;
      4'd6, 4'd9:  g = GRP_LR;
      4'd7, 4'd8:  g = GRP_TL;
      4'd5, 4'd10: g = GRP_SADDLE;
      default:     g = GRP_NONE;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ src/msq_cross.sv @@
// ----------------------------------------------------------------------------
// msq_cross: one edge-crossing lane
// Computes p0 + trunc((p1 - p0) * f0 / (f0 - f1)) in a fixed pipeline:
// magnitudes, split multiply, product sum, then one restoring divide step
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_cross import msq_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  signed [COORD_WIDTH-1:0] p0_i,
  input  wire  signed [COORD_WIDTH-1:0] p1_i,
  input  wire  signed [PhiWidth-1:0]    f0_i,
  input  wire  signed [PhiWidth-1:0]    f1_i,
  output logic signed [COORD_WIDTH-1:0] cross_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned HW = (CW > 32) ? CW - 32 : 1;  // high slice of distance
  localparam int unsigned DW = 32 + HW;
  localparam int unsigned PW = DW + PhiWidth;            // product width
  localparam int unsigned RW = PhiWidth + 2;             // partial remainder

  // stage A: magnitudes and signs
  logic          [CW-1:0]       dmag;
  logic signed   [PhiWidth:0]   den;
  logic          [PhiWidth-1:0] fmag;
  logic          [PhiWidth:0]   cmag;
  logic                         dneg;

  always_comb begin
    dneg = (p1_i < p0_i);
    dmag = dneg ? CW'(p0_i - p1_i) : CW'(p1_i - p0_i);
    den  = {f0_i[PhiWidth-1], f0_i} - {f1_i[PhiWidth-1], f1_i};
    fmag = f0_i[PhiWidth-1] ? (~f0_i + 1'b1) : f0_i;
    cmag = den[PhiWidth] ? (~den + 1'b1) : den;
  end

  logic [CW-1:0]       a_dmag_q;
  logic [PhiWidth-1:0] a_fmag_q;
  logic [PhiWidth:0]   a_cmag_q;
  logic [CW-1:0]       a_p0_q;
  logic                a_neg_q, a_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dmag_q <= dmag;
      a_fmag_q <= fmag;
      a_cmag_q <= cmag;
      a_p0_q   <= p0_i;
      a_neg_q  <= dneg ^ f0_i[PhiWidth-1] ^ den[PhiWidth];
      a_zero_q <= (cmag == '0);
    end
  end

  // stage B: partial products, low 32 and high HW bits of distance by |f0|
  logic [DW-1:0] dext;
  assign dext = DW'(a_dmag_q);

  logic [63:0]          b_pl_q;
  logic [HW+31:0]       b_ph_q;
  logic [PhiWidth:0]    b_cmag_q;
  logic [CW-1:0]        b_p0_q;
  logic                 b_neg_q, b_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_pl_q   <= dext[31:0] * a_fmag_q;
      b_ph_q   <= dext[DW-1:32] * a_fmag_q;
      b_cmag_q <= a_cmag_q;
      b_p0_q   <= a_p0_q;
      b_neg_q  <= a_neg_q;
      b_zero_q <= a_zero_q;
    end
  end

  // stage C: full product, split into starting remainder and dividend bits
  logic [PW-1:0] prod;
  assign prod = PW'(b_pl_q) + (PW'(b_ph_q) << 32);

  logic [RW-1:0]     c_rem_q;
  logic [CW-1:0]     c_w_q;
  logic [PhiWidth:0] c_cmag_q;
  logic [CW-1:0]     c_p0_q;
  logic              c_neg_q, c_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_rem_q  <= RW'(prod >> CW);
      c_w_q    <= prod[CW-1:0];
      c_cmag_q <= b_cmag_q;
      c_p0_q   <= b_p0_q;
      c_neg_q  <= b_neg_q;
      c_zero_q <= b_zero_q;
    end
  end

  // divide stages: one quotient bit each, shifted into the dividend word
  logic [RW-1:0]     d_rem_q  [CW];
  logic [CW-1:0]     d_w_q    [CW];
  logic [PhiWidth:0] d_cmag_q [CW];
  logic [CW-1:0]     d_p0_q   [CW];
  logic              d_neg_q  [CW];
  logic              d_zero_q [CW];

  logic [RW-1:0] st_rem [CW];
  logic [CW-1:0] st_w   [CW];

  always_comb begin
    for (int k = 0; k < CW; k++) begin
      logic [RW-1:0]     r_in, t;
      logic [CW-1:0]     w_in;
      logic [PhiWidth:0] c_in;
      r_in = (k == 0) ? c_rem_q  : d_rem_q[(k == 0) ? 0 : k - 1];
      w_in = (k == 0) ? c_w_q    : d_w_q[(k == 0) ? 0 : k - 1];
      c_in = (k == 0) ? c_cmag_q : d_cmag_q[(k == 0) ? 0 : k - 1];
      t = {r_in[RW-2:0], w_in[CW-1]};
      if (t >= RW'(c_in)) begin
        st_rem[k] = t - RW'(c_in);
        st_w[k]   = {w_in[CW-2:0], 1'b1};
      end else begin
        st_rem[k] = t;
        st_w[k]   = {w_in[CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CW; k++) begin
        d_rem_q[k] <= st_rem[k];
        d_w_q[k]   <= st_w[k];
        if (k == 0) begin
          d_cmag_q[k] <= c_cmag_q;
          d_p0_q[k]   <= c_p0_q;
          d_neg_q[k]  <= c_neg_q;
          d_zero_q[k] <= c_zero_q;
        end else begin
          d_cmag_q[k] <= d_cmag_q[k-1];
          d_p0_q[k]   <= d_p0_q[k-1];
          d_neg_q[k]  <= d_neg_q[k-1];
          d_zero_q[k] <= d_zero_q[k-1];
        end
      end
    end
  end

  // apply sign; an edge with equal corner values lands on p0
  logic [CW-1:0] quo;
  assign quo     = d_zero_q[CW-1] ? '0 : d_w_q[CW-1];
  assign cross_o = d_neg_q[CW-1] ? (d_p0_q[CW-1] - quo) : (d_p0_q[CW-1] + quo);

endmodule

`default_nettype wire

@@ src/marching_squares_cell_top.sv @@
// ----------------------------------------------------------------------------
// marching_squares_cell_top: marching-squares cell classifier
// Request path: input register, then both crossing lanes, then output register.
// Throughput: one cell per cycle while the output is not stalled; set by the per-stage divide in each lane.
// Whole pipeline holds while a result waits at the output.
// Reset: clears all valid bits; no memories, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_top import msq_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid,
  output logic        s_tready,
  // phi_upper_left, phi_lower_left, phi_lower_right, phi_upper_right,
  // left_x, right_x, top_y, bottom_y; zero padded to bytes
  input  wire  [((4*PhiWidth+4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // start_x, start_y, end_x, end_y; zero padded to bytes
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // has_segment, case_index[3:0], is_saddle
  output logic [5:0]  m_tuser
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned IN_W   = 4*PhiWidth + 4*CW;
  localparam int unsigned OUT_W  = 4*CW;
  localparam int unsigned OUT_TW = ((OUT_W+7)/8)*8;
  localparam int unsigned LD     = CW + 3;   // lane depth

  typedef struct packed {
    logic [3:0]    idx;
    logic          seg;
    logic          saddle;
    logic [CW-1:0] sfix;
    logic [CW-1:0] efix;
    logic          s_is_y;
    logic          e_is_y;
  } side_t;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input register
  logic [IN_W-1:0] in_q;
  logic [LD:0]     vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) in_q <= s_tdata[IN_W-1:0];
  end

  logic signed [PhiWidth-1:0] ful, fll, flr, fur;
  logic signed [CW-1:0]       lx, rx, ty, by;
  assign ful = in_q[0*PhiWidth +: PhiWidth];
  assign fll = in_q[1*PhiWidth +: PhiWidth];
  assign flr = in_q[2*PhiWidth +: PhiWidth];
  assign fur = in_q[3*PhiWidth +: PhiWidth];
  assign lx  = in_q[4*PhiWidth + 0*CW +: CW];
  assign rx  = in_q[4*PhiWidth + 1*CW +: CW];
  assign ty  = in_q[4*PhiWidth + 2*CW +: CW];
  assign by  = in_q[4*PhiWidth + 3*CW +: CW];

  // classify and steer both lanes
  logic [3:0]           idx;
  msq_group_e           grp;
  logic signed [CW-1:0] a_p0, a_p1, b_p0, b_p1;
  logic signed [PhiWidth-1:0] a_f0, a_f1, b_f0, b_f1;
  side_t                side;

  always_comb begin
    idx = {ful[PhiWidth-1], fll[PhiWidth-1], flr[PhiWidth-1], fur[PhiWidth-1]};
    grp = msq_group(idx);
    a_p0 = rx; a_p1 = lx; a_f0 = fur; a_f1 = ful;
    b_p0 = by; b_p1 = ty; b_f0 = flr; b_f1 = fur;
    side.idx    = idx;
    side.seg    = 1'b1;
    side.saddle = 1'b0;
    side.sfix   = ty;
    side.s_is_y = 1'b0;
    side.efix   = rx;
    side.e_is_y = 1'b1;
    case (grp)
      GRP_TR: begin
      end
      GRP_BR: begin
        a_p0 = lx; a_p1 = rx; a_f0 = fll; a_f1 = flr;
        b_p0 = ty; b_p1 = by; b_f0 = fur; b_f1 = flr;
        side.sfix = by;
      end
      GRP_TB: begin
        b_p0 = lx; b_p1 = rx; b_f0 = fll; b_f1 = flr;
        side.efix = by; side.e_is_y = 1'b0;
      end
      GRP_LB: begin
        a_p0 = ty; a_p1 = by; a_f0 = ful; a_f1 = fll;
        b_p0 = lx; b_p1 = rx; b_f0 = fll; b_f1 = flr;
        side.sfix = lx; side.s_is_y = 1'b1;
        side.efix = by; side.e_is_y = 1'b0;
      end
      GRP_LR: begin
        a_p0 = ty; a_p1 = by; a_f0 = ful; a_f1 = fll;
        side.sfix = lx; side.s_is_y = 1'b1;
      end
      GRP_TL: begin
        a_p0 = lx; a_p1 = rx; a_f0 = ful; a_f1 = fur;
        b_p0 = ty; b_p1 = by; b_f0 = ful; b_f1 = fll;
        side.efix = lx;
      end
      GRP_SADDLE: begin
        side.seg = 1'b0; side.saddle = 1'b1;
      end
      default: begin
        side.seg = 1'b0;
      end
    endcase
  end

  // crossing lanes: start point and end point
  logic signed [CW-1:0] a_cross, b_cross;

  msq_cross #(.COORD_WIDTH(CW)) u_lane_start (
    .clk_i  (clk_i),
    .en_i   (adv),
    .p0_i   (a_p0),
    .p1_i   (a_p1),
    .f0_i   (a_f0),
    .f1_i   (a_f1),
    .cross_o(a_cross)
  );

  msq_cross #(.COORD_WIDTH(CW)) u_lane_end (
    .clk_i  (clk_i),
    .en_i   (adv),
    .p0_i   (b_p0),
    .p1_i   (b_p1),
    .f0_i   (b_f0),
    .f1_i   (b_f1),
    .cross_o(b_cross)
  );

  // sideband delay matching the lanes
  side_t side_q [LD];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < LD; k++) begin
        if (k == 0) side_q[k] <= side;
        else        side_q[k] <= side_q[k-1];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld_q    <= {vld_q[LD-1:0], s_tvalid};
      m_tvalid <= vld_q[LD];
    end
  end

  // merge lane results into the segment
  side_t         sm;
  logic [CW-1:0] sx, sy, ex, ey;

  always_comb begin
    sm = side_q[LD-1];
    sx = '0; sy = '0; ex = '0; ey = '0;
    if (sm.seg) begin
      sx = sm.s_is_y ? sm.sfix : a_cross;
      sy = sm.s_is_y ? a_cross : sm.sfix;
      ex = sm.e_is_y ? sm.efix : b_cross;
      ey = sm.e_is_y ? b_cross : sm.efix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_tdata <= OUT_TW'({ey, ex, sy, sx});
      m_tuser <= {sm.saddle, sm.idx, sm.seg};
    end
  end

  // checks
  a_saddle_no_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[5] |-> !m_tuser[0])
    else $error("saddle cell reported a segment");

  a_saddle_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tuser[5] == (m_tuser[4:1] == 4'd5 || m_tuser[4:1] == 4'd10)))
    else $error("saddle flag does not match case index");

  a_no_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
    else $error("empty cell carries nonzero endpoints");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire
